// ===== rtl/slfp_pkg.sv =====
// Package for the status line field parser: sizes, widths, result type, prefix table.
`timescale 1ns / 1ps

package slfp_pkg;

    // Field buffer sizes in characters, terminator included
    localparam int STATE_SIZE   = 16;
    localparam int MESSAGE_SIZE = 64;
    localparam int MODEL_SIZE   = 32;

    // Counter widths; a counter never exceeds SIZE-1
    localparam int STATE_CW = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;
    localparam int MSG_CW   = (MESSAGE_SIZE > 1) ? $clog2(MESSAGE_SIZE) : 1;
    localparam int MDL_CW   = (MODEL_SIZE > 1) ? $clog2(MODEL_SIZE) : 1;

    // Width used to bring any counter to a common size before masking
    localparam int WIDE_W = 9;

    localparam logic [2:0] PREFIX_LEN = 3'd7;
    localparam logic [7:0] SEP_CHAR   = 8'h7C;   // '|'
    localparam logic [6:0] CTX_MAX    = 7'd100;
    localparam logic [6:0] ACC_SAT    = 7'd101;

    // field_sel codes
    localparam logic [1:0] SEL_NONE    = 2'd0;
    localparam logic [1:0] SEL_STATE   = 2'd1;
    localparam logic [1:0] SEL_MESSAGE = 2'd2;
    localparam logic [1:0] SEL_MODEL   = 2'd3;

    localparam logic signed [7:0] CTX_ABSENT = -8'sd1;

    typedef struct packed {
        logic [1:0]        field_sel;
        logic [7:0]        char_out;
        logic [5:0]        char_pos;
        logic              line_done;
        logic              line_ok;
        logic [3:0]        state_chars;
        logic [5:0]        message_len;
        logic [4:0]        model_chars;
        logic signed [7:0] ctx_percent;
    } result_t;

    // "STATUS|" one character per position; position 7 is never matched
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h53;  // S
            3'd1:    c = 8'h54;  // T
            3'd2:    c = 8'h41;  // A
            3'd3:    c = 8'h54;  // T
            3'd4:    c = 8'h55;  // U
            3'd5:    c = 8'h53;  // S
            3'd6:    c = 8'h7C;  // |
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // space, tab, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

// ===== rtl/slfp_if.sv =====
// Channel interfaces for the status line field parser: input characters and results.
`timescale 1ns / 1ps

interface slfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_line;

    modport source (output valid, output ch, output end_of_line, input ready);
    modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface slfp_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        field_sel;
    logic [7:0]        char_out;
    logic [5:0]        char_pos;
    logic              line_done;
    logic              line_ok;
    logic [3:0]        state_chars;
    logic [5:0]        message_len;
    logic [4:0]        model_chars;
    logic signed [7:0] ctx_percent;

    modport source (output valid, output field_sel, output char_out, output char_pos,
                    output line_done, output line_ok, output state_chars,
                    output message_len, output model_chars, output ctx_percent,
                    input ready);
    modport sink   (input valid, input field_sel, input char_out, input char_pos,
                    input line_done, input line_ok, input state_chars,
                    input message_len, input model_chars, input ctx_percent,
                    output ready);
endinterface

// ===== rtl/status_line_field_parser.sv =====
// Top level of the status line field parser: per-character state update and result buffer.
`timescale 1ns / 1ps
//
// Usage:
//   chars   : one character item per cycle while chars.ready is high;
//             end_of_line = 1 closes the line (its ch is ignored). The line
//             must start with "STATUS|", then state|message|model|context.
//   results : exactly one item per input item, in order. A character that
//             lands in a field comes out with field_sel/char_pos; the
//             consumer keeps it only if the line's end item shows line_ok.
//             The end item carries line_done, line_ok, the three lengths and
//             ctx_percent (0..100, or -1 with no context field).
// Output: each result is registered, going through the skid stage first if the output stalls.
// Throughput: one item per cycle while chars.ready is high; the next parser state
//   is computed from the registered state and the incoming character.
// Stall: the output register plus a one-item skid stage keep chars.ready
//   high for one more item after the receiver stops; after that ready drops
//   until the skid stage drains. Nothing is lost or repeated.
// Reset: rst_n (async, active low) returns to prefix matching with all
//   counters cleared and both result stages empty. Every end-of-line item
//   also returns the parser to that state for the next line.
//

module status_line_field_parser
    import slfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    slfp_in_if.sink     chars,
    slfp_out_if.source  results
);

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_STATE,
        PH_MESSAGE,
        PH_MODEL,
        PH_CONTEXT,
        PH_FAIL
    } phase_t;

    typedef enum logic [1:0] {
        NP_SKIP,
        NP_DIGITS,
        NP_DONE
    } num_phase_t;

    // parser state
    phase_t              phase_reg,  phase_next;
    logic [2:0]          prefix_pos_reg, prefix_pos_next;
    logic [STATE_CW-1:0] state_count_reg, state_count_next;
    logic [MSG_CW-1:0]   message_count_reg, message_count_next;
    logic [MDL_CW-1:0]   model_count_reg, model_count_next;
    num_phase_t          num_phase_reg, num_phase_next;
    logic                num_neg_reg, num_neg_next;
    logic [6:0]          num_acc_reg, num_acc_next;

    // output register and skid stage
    result_t out_reg,  out_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    result_t res;
    logic    in_fire;
    logic    out_fire;

    logic [WIDE_W-1:0] state_w;
    logic [WIDE_W-1:0] message_w;
    logic [WIDE_W-1:0] model_w;
    logic [9:0]        acc_mul;
    logic [7:0]        c;

    assign chars.ready = !skid_valid_reg;
    assign in_fire     = chars.valid && chars.ready;
    assign out_fire    = out_valid_reg && results.ready;
    assign c           = chars.ch;

    assign state_w   = WIDE_W'(state_count_reg);
    assign message_w = WIDE_W'(message_count_reg);
    assign model_w   = WIDE_W'(model_count_reg);

    // accumulator * 10 + digit, saturated at 101 below
    assign acc_mul = 10'({num_acc_reg, 3'b000}) + 10'({num_acc_reg, 1'b0})
                   + 10'(c - 8'h30);

    // Next parser state and the result for the incoming item
    always_comb
    begin
        phase_next         = phase_reg;
        prefix_pos_next    = prefix_pos_reg;
        state_count_next   = state_count_reg;
        message_count_next = message_count_reg;
        model_count_next   = model_count_reg;
        num_phase_next     = num_phase_reg;
        num_neg_next       = num_neg_reg;
        num_acc_next       = num_acc_reg;

        res           = '0;
        res.field_sel = SEL_NONE;

        if (chars.end_of_line)
        begin
            res.line_done = 1'b1;
            if (phase_reg == PH_MESSAGE || phase_reg == PH_MODEL || phase_reg == PH_CONTEXT)
            begin
                res.line_ok     = 1'b1;
                res.state_chars = state_w[3:0];
                res.message_len = message_w[5:0];
                res.model_chars = (phase_reg == PH_MESSAGE) ? 5'd0 : model_w[4:0];
                if (phase_reg == PH_CONTEXT)
                begin
                    if (num_neg_reg)
                        res.ctx_percent = 8'sd0;
                    else if (num_acc_reg > CTX_MAX)
                        res.ctx_percent = 8'sd100;
                    else
                        res.ctx_percent = signed'({1'b0, num_acc_reg});
                end
                else
                begin
                    res.ctx_percent = CTX_ABSENT;
                end
            end
            // back to the start for the next line
            phase_next         = PH_PREFIX;
            prefix_pos_next    = '0;
            state_count_next   = '0;
            message_count_next = '0;
            model_count_next   = '0;
            num_phase_next     = NP_SKIP;
            num_neg_next       = 1'b0;
            num_acc_next       = '0;
        end
        else
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (c == prefix_char(prefix_pos_reg))
                    begin
                        prefix_pos_next = prefix_pos_reg + 3'd1;
                        if (prefix_pos_next >= PREFIX_LEN)
                            phase_next = PH_STATE;
                    end
                    else
                    begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_STATE:
                begin
                    if (c == SEP_CHAR)
                        phase_next = (state_count_reg == '0) ? PH_FAIL : PH_MESSAGE;
                    else if (state_count_reg >= STATE_CW'(STATE_SIZE - 1))
                        phase_next = PH_FAIL;
                    else
                    begin
                        res.field_sel    = SEL_STATE;
                        res.char_out     = c;
                        res.char_pos     = state_w[5:0];
                        state_count_next = state_count_reg + 1'b1;
                    end
                end
                PH_MESSAGE:
                begin
                    if (c == SEP_CHAR)
                        phase_next = PH_MODEL;
                    else if (message_count_reg < MSG_CW'(MESSAGE_SIZE - 1))
                    begin
                        res.field_sel      = SEL_MESSAGE;
                        res.char_out       = c;
                        res.char_pos       = message_w[5:0];
                        message_count_next = message_count_reg + 1'b1;
                    end
                end
                PH_MODEL:
                begin
                    if (c == SEP_CHAR)
                        phase_next = PH_CONTEXT;
                    else if (model_count_reg < MDL_CW'(MODEL_SIZE - 1))
                    begin
                        res.field_sel    = SEL_MODEL;
                        res.char_out     = c;
                        res.char_pos     = model_w[5:0];
                        model_count_next = model_count_reg + 1'b1;
                    end
                end
                PH_CONTEXT:
                begin
                    // atoi-style: skip whitespace, one sign, then digits
                    case (num_phase_reg)
                        NP_SKIP:
                        begin
                            if (!is_space(c))
                            begin
                                num_phase_next = NP_DIGITS;
                                if (c == 8'h2D)
                                    num_neg_next = 1'b1;
                                else if (c == 8'h2B)
                                    num_neg_next = num_neg_reg;
                                else if (c >= 8'h30 && c <= 8'h39)
                                    num_acc_next = (acc_mul > 10'(ACC_SAT)) ? ACC_SAT
                                                                            : acc_mul[6:0];
                                else
                                    num_phase_next = NP_DONE;
                            end
                        end
                        NP_DIGITS:
                        begin
                            if (c >= 8'h30 && c <= 8'h39)
                                num_acc_next = (acc_mul > 10'(ACC_SAT)) ? ACC_SAT
                                                                        : acc_mul[6:0];
                            else
                                num_phase_next = NP_DONE;
                        end
                        default:
                        begin
                            num_phase_next = num_phase_reg;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Output register with one skid entry behind it
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_PREFIX;
            prefix_pos_reg    <= '0;
            state_count_reg   <= '0;
            message_count_reg <= '0;
            model_count_reg   <= '0;
            num_phase_reg     <= NP_SKIP;
            num_neg_reg       <= 1'b0;
            num_acc_reg       <= '0;
            out_reg           <= '0;
            out_valid_reg     <= 1'b0;
            skid_reg          <= '0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg         <= phase_next;
                prefix_pos_reg    <= prefix_pos_next;
                state_count_reg   <= state_count_next;
                message_count_reg <= message_count_next;
                model_count_reg   <= model_count_next;
                num_phase_reg     <= num_phase_next;
                num_neg_reg       <= num_neg_next;
                num_acc_reg       <= num_acc_next;
            end
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
            skid_reg       <= skid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.field_sel   = out_reg.field_sel;
    assign results.char_out    = out_reg.char_out;
    assign results.char_pos    = out_reg.char_pos;
    assign results.line_done   = out_reg.line_done;
    assign results.line_ok     = out_reg.line_ok;
    assign results.state_chars = out_reg.state_chars;
    assign results.message_len = out_reg.message_len;
    assign results.model_chars = out_reg.model_chars;
    assign results.ctx_percent = out_reg.ctx_percent;

endmodule

// ===== test/testbench.sv =====
// Testbench for status_line_field_parser: random lines, handshake stalls, predicted results.
`timescale 1ns / 1ps

module testbench;
    import slfp_pkg::*;

    // Random part stops growing once this many items are queued
    localparam int ITEM_TARGET = 850;
    // Cycles with no item moving on either side before the run is declared hung
    localparam int HANG_LIMIT = 3000;
    // Long receiver hold-off used to back the block up into its input
    localparam int HOLD_CYCLES = 80;

    localparam string STATUS_HDR = "STATUS|";
    localparam logic [7:0] MINUS_CH = "-";
    localparam logic [7:0] PLUS_CH  = "+";
    localparam logic [7:0] ZERO_CH  = "0";
    localparam logic [7:0] NINE_CH  = "9";
    localparam logic [7:0] BLANK_CH = 8'h20;
    localparam logic [7:0] TAB_CH   = 8'h09;
    localparam logic [7:0] CR_CH    = 8'h0D;

    // Where the line parser stands
    typedef enum logic [2:0] {
        AT_PREFIX,
        IN_STATE,
        IN_MESSAGE,
        IN_MODEL,
        IN_CONTEXT,
        LINE_BAD
    } parse_phase_e;

    // Where the context number reader stands
    typedef enum logic [1:0] {
        NUM_SKIP_WS,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } char_item_t;

    logic clk = 1'b0;
    logic rst_n;

    slfp_in_if  chars_if ();
    slfp_out_if res_if ();

    status_line_field_parser uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (res_if)
    );

    always #5 clk = ~clk;

    char_item_t pending_chars[$];   // characters not yet offered
    result_t    result_q[$];        // predicted results, oldest first

    int char_total;
    int sent_cnt;
    int stage;
    int err_count;
    int quiet_cycles;
    int hold_left;
    logic pressure_done;

    // Parser shadow state
    parse_phase_e ps;
    int           hdr_idx;
    int           st_cnt;
    int           msg_cnt;
    int           mdl_cnt;
    num_phase_e   num_ph;
    logic         num_neg;
    int           num_acc;

    // ------------------------------------------------------------------
    // Line parser prediction
    // ------------------------------------------------------------------

    function automatic void parser_clear();
        ps      = AT_PREFIX;
        hdr_idx = 0;
        st_cnt  = 0;
        msg_cnt = 0;
        mdl_cnt = 0;
        num_ph  = NUM_SKIP_WS;
        num_neg = 1'b0;
        num_acc = 0;
    endfunction

    // One character (or end of line) in, one result out; updates the shadow state.
    function automatic result_t parse_char(input logic [7:0] c, input logic eol);
        result_t r;
        logic    ws;
        logic    taken;
        int      v;
        r     = '0;
        ws    = (c == BLANK_CH) || (c >= TAB_CH && c <= CR_CH);
        taken = 1'b0;

        if (eol) begin
            r.line_done = 1'b1;
            // a line is good once it has got past the state separator
            if (ps == IN_MESSAGE || ps == IN_MODEL || ps == IN_CONTEXT) begin
                r.line_ok     = 1'b1;
                r.state_chars = 4'(st_cnt);
                r.message_len = 6'(msg_cnt);
                r.model_chars = (ps == IN_MESSAGE) ? 5'd0 : 5'(mdl_cnt);
                if (ps == IN_CONTEXT)
                    r.ctx_percent = num_neg ? 8'sd0
                                  : 8'(num_acc > int'(CTX_MAX) ? int'(CTX_MAX) : num_acc);
                else
                    r.ctx_percent = CTX_ABSENT;
            end
            parser_clear();
            return r;
        end

        case (ps)
            AT_PREFIX:
            begin
                if (c == STATUS_HDR[hdr_idx]) begin
                    hdr_idx++;
                    if (hdr_idx >= int'(PREFIX_LEN))
                        ps = IN_STATE;
                end
                else
                    ps = LINE_BAD;
            end
            IN_STATE:
            begin
                if (c == SEP_CHAR)
                    ps = (st_cnt == 0) ? LINE_BAD : IN_MESSAGE;
                else if (st_cnt + 1 >= STATE_SIZE)
                    ps = LINE_BAD;   // state too long for its buffer
                else begin
                    r.field_sel = SEL_STATE;
                    r.char_out  = c;
                    r.char_pos  = 6'(st_cnt);
                    st_cnt++;
                end
            end
            IN_MESSAGE:
            begin
                if (c == SEP_CHAR)
                    ps = IN_MODEL;
                else if (msg_cnt + 1 < MESSAGE_SIZE) begin
                    r.field_sel = SEL_MESSAGE;
                    r.char_out  = c;
                    r.char_pos  = 6'(msg_cnt);
                    msg_cnt++;
                end
            end
            IN_MODEL:
            begin
                if (c == SEP_CHAR)
                    ps = IN_CONTEXT;
                else if (mdl_cnt + 1 < MODEL_SIZE) begin
                    r.field_sel = SEL_MODEL;
                    r.char_out  = c;
                    r.char_pos  = 6'(mdl_cnt);
                    mdl_cnt++;
                end
            end
            IN_CONTEXT:
            begin
                // atoi-like: blanks, one sign, digits; anything else ends it
                if (num_ph == NUM_SKIP_WS) begin
                    if (ws)
                        taken = 1'b1;
                    else begin
                        num_ph = NUM_DIGITS;
                        if (c == MINUS_CH) begin
                            num_neg = 1'b1;
                            taken   = 1'b1;
                        end
                        else if (c == PLUS_CH)
                            taken = 1'b1;
                    end
                end
                if (!taken && num_ph == NUM_DIGITS) begin
                    if (c >= ZERO_CH && c <= NINE_CH) begin
                        v       = num_acc * 10 + int'(c - ZERO_CH);
                        num_acc = (v > int'(ACC_SAT)) ? int'(ACC_SAT) : v;
                    end
                    else
                        num_ph = NUM_DONE;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Line builders
    // ------------------------------------------------------------------

    task automatic add_char(input logic [7:0] c);
        pending_chars.push_back('{ch: c, eol: 1'b0});
    endtask

    // ch of the terminator is don't-care, so it gets random bits too
    task automatic add_eol();
        pending_chars.push_back('{ch: 8'($urandom), eol: 1'b1});
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    // n field characters; separators only when allowed
    task automatic add_text(input int n, input logic allow_sep);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            do
                c = 8'($urandom);
            while (!allow_sep && c == SEP_CHAR);
            add_char(c);
        end
    endtask

    task automatic add_context();
        int pick;
        int n;
        for (int i = $urandom_range(0, 3); i > 0; i--) begin
            pick = $urandom_range(0, 5);
            add_char(pick == 5 ? BLANK_CH : TAB_CH + 8'(pick));
        end
        case ($urandom_range(0, 6))
            0:       add_char(MINUS_CH);
            1:       add_char(PLUS_CH);
            2:       add_text(1, 1'b1);   // junk where the number should start
            default: ;
        endcase
        if ($urandom_range(0, 4) == 0)
            add_char(ZERO_CH);            // leading zero
        case ($urandom_range(0, 6))
            0:       add_str("100");
            1:       add_str("101");
            2:       add_str($sformatf("%0d", $urandom_range(0, 9)));
            3:       add_str($sformatf("%0d", $urandom_range(0, 99)));
            4:       add_str($sformatf("%0d", $urandom_range(0, 99999)));
            5:       add_str("99");
            default: ;
        endcase
        add_text($urandom_range(0, 3), 1'b1);  // trailer, may hold '|' or digits
    endtask

    task automatic add_line();
        int kind;
        int cut;
        int k;
        int pick;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            // pure noise
            add_text($urandom_range(0, 12), 1'b1);
            add_eol();
        end
        else if (kind < 16) begin
            // header broken at some position
            k = $urandom_range(0, 6);
            add_str(STATUS_HDR.substr(0, k - 1));
            do
                c = 8'($urandom);
            while (c == STATUS_HDR[k]);
            add_char(c);
            add_text($urandom_range(0, 5), 1'b1);
            add_eol();
        end
        else begin
            // well-formed line, sometimes cut short after a field
            cut = $urandom_range(0, 11);
            add_str(STATUS_HDR);
            if (cut == 0) begin
                add_eol();
                return;
            end
            pick = $urandom_range(0, 9);
            add_text(pick == 0 ? 0 : pick == 1 ? STATE_SIZE - 2 :
                     pick == 2 ? $urandom_range(STATE_SIZE - 1, STATE_SIZE + 1) :
                     $urandom_range(1, 8), 1'b0);
            if (cut == 1) begin
                add_eol();
                return;
            end
            add_char(SEP_CHAR);
            add_text($urandom_range(0, 7) == 0 ? $urandom_range(MESSAGE_SIZE - 4, MESSAGE_SIZE + 6)
                                               : $urandom_range(0, 12), 1'b0);
            if (cut == 2) begin
                add_eol();
                return;
            end
            add_char(SEP_CHAR);
            add_text($urandom_range(0, 7) == 0 ? $urandom_range(MODEL_SIZE - 3, MODEL_SIZE + 3)
                                               : $urandom_range(0, 8), 1'b0);
            if (cut == 3) begin
                add_eol();
                return;
            end
            add_char(SEP_CHAR);
            add_context();
            add_eol();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        err_count++;
        $display("testbench: mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Run phases follow the share of items sent so far:
    //   0 no idling, 1 sender mostly idle, 2 receiver mostly stalled,
    //   3 both idle a quarter of the time, 4 long receiver hold-off then free run.
    always_comb
        stage = (char_total > 0) ? (sent_cnt * 5) / char_total : 0;

    // Character driver: keeps an item on the bus until taken, then maybe idles.
    always @(posedge clk or negedge rst_n)
    begin : char_driver
        char_item_t nxt;
        int idle_pct;
        if (!rst_n) begin
            chars_if.valid       <= 1'b0;
            chars_if.ch          <= 8'h00;
            chars_if.end_of_line <= 1'b0;
        end
        else begin
            idle_pct = (stage == 1) ? 78 : (stage == 3) ? 25 : 0;
            if (chars_if.valid && chars_if.ready) begin
                result_q.push_back(parse_char(chars_if.ch, chars_if.end_of_line));
                sent_cnt <= sent_cnt + 1;
            end
            if (!chars_if.valid || chars_if.ready) begin
                if (pending_chars.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = pending_chars.pop_front();
                    chars_if.valid       <= 1'b1;
                    chars_if.ch          <= nxt.ch;
                    chars_if.end_of_line <= nxt.eol;
                end
                else
                    chars_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off so the skid stage fills
    // and the block must drop chars.ready while the driver keeps offering.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_if.ready  <= 1'b0;
            hold_left     <= 0;
            pressure_done <= 1'b0;
        end
        else if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (stage == 4 && !pressure_done) begin
            res_if.ready  <= 1'b0;
            hold_left     <= HOLD_CYCLES - 1;
            pressure_done <= 1'b1;
        end
        else
            res_if.ready <= $urandom_range(0, 99) >=
                            ((stage == 2) ? 78 : (stage == 3) ? 25 : 0);
    end

    // Result monitor: every result taken is matched against the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (result_q.size() == 0)
                report_mismatch("result with no item outstanding");
            else begin
                want = result_q.pop_front();
                check_field("field_sel",   res_if.field_sel,   want.field_sel);
                check_field("char_out",    res_if.char_out,    want.char_out);
                check_field("char_pos",    res_if.char_pos,    want.char_pos);
                check_field("line_done",   res_if.line_done,   want.line_done);
                check_field("line_ok",     res_if.line_ok,     want.line_ok);
                check_field("state_chars", res_if.state_chars, want.state_chars);
                check_field("message_len", res_if.message_len, want.message_len);
                check_field("model_chars", res_if.model_chars, want.model_chars);
                check_field("ctx_percent", int'(res_if.ctx_percent), int'(want.ctx_percent));
            end
        end
    end

    // Watchdog: nothing moving on either channel for too long means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n                = 1'b0;
        chars_if.valid       = 1'b0;
        chars_if.ch          = 8'h00;
        chars_if.end_of_line = 1'b0;
        res_if.ready         = 1'b0;
        sent_cnt             = 0;
        err_count            = 0;
        quiet_cycles         = 0;
        parser_clear();

        // Directed lines: byte extremes as state and message, an empty line,
        // a header mismatch, and an empty state field.
        add_str(STATUS_HDR);
        add_char(8'hFF);
        add_char(SEP_CHAR);
        add_char(8'h00);
        add_eol();
        add_str("Q");
        add_eol();
        add_eol();
        add_str("STATUS||");
        add_eol();

        while (pending_chars.size() < ITEM_TARGET)
            add_line();
        char_total = pending_chars.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: everything offered, taken, and answered
        do
            @(posedge clk);
        while (pending_chars.size() != 0 || chars_if.valid || result_q.size() != 0);
        repeat (4) @(posedge clk);

        if (err_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== status_line_field_parser.f =====
rtl/slfp_pkg.sv
rtl/slfp_if.sv
rtl/status_line_field_parser.sv
test/testbench.sv
